>>> src/bdq_pkg.sv
// Shared command and status codes for the bounded deque with search.
package bdq_pkg;

    localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
    localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
    localparam logic [3:0] CMD_POP_BACK   = 4'd3;
    localparam logic [3:0] CMD_READ       = 4'd4;
    localparam logic [3:0] CMD_WRITE      = 4'd5;
    localparam logic [3:0] CMD_FIND_EQ    = 4'd6;
    localparam logic [3:0] CMD_FIND_GT    = 4'd7;
    localparam logic [3:0] CMD_CLEAR      = 4'd8;
    localparam logic [3:0] CMD_COUNT      = 4'd9;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_BADIDX = 2'd2;
    localparam t_status ST_FULL   = 2'd3;

    localparam int WORD_W = 32;

endpackage

>>> src/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bounded_deque_with_search_top.sv
// Top level of the bounded deque with indexed access and sequential search.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  command  | i_in_valid / o_in_ready    | i_cmd, i_index, i_value
//  result   | o_out_valid / i_out_ready  | o_data, o_position, o_found, o_status,
//           |                            | o_count
//
//  Push, write, clear, count and refused commands: result registered in the cycle after acceptance.
//  Pop and read: the word passes the registered read port of the entry store, then S_READ registers it.
//  Searches: the single comparator walks the store from the front one entry a cycle; the
//  result is loaded on the first hit, after the last entry, or at once if the deque is empty.
//  o_in_ready is low while a transaction is in progress and while a result waits.
//  Synchronous active-low reset clears head, count and control; the store is not cleared.
module bounded_deque_with_search_top
    import bdq_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_cmd,
    input  logic [7:0]         i_index,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_data,
    output logic [7:0]         o_position,
    output logic               o_found,
    output logic [1:0]         o_status,
    output logic [8:0]         o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW : 8;
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, pos};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    logic [1:0]         r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_gt, n_gt;
    logic signed [31:0] r_value, n_value;

    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_data, n_data;
    logic [7:0]         r_position, n_position;
    logic               r_found, n_found;
    t_status            r_status, n_status;
    logic [8:0]         r_out_count, n_out_count;

    logic               accept;
    logic               load;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic [WORD_W-1:0]  rdata;
    logic               full;
    logic               empty;
    logic               bad_idx;
    logic               hit;
    logic               last;
    logic [XW-1:0]      idx_x;
    logic [CW-1:0]      cnt_m1;

    bdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign idx_x   = XW'(i_index);
    assign bad_idx = (idx_x >= XW'(r_count));
    assign cnt_m1  = r_count - CW'(1);
    assign hit     = r_gt ? ($signed(rdata) > r_value) : (rdata == r_value);
    assign last    = ((CW'(r_idx) + CW'(1)) == r_count);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_gt        = r_gt;
        n_value     = r_value;
        n_out_valid = r_out_valid && !i_out_ready;
        n_data      = r_data;
        n_position  = r_position;
        n_found     = r_found;
        n_status    = r_status;
        n_out_count = r_out_count;
        we          = 1'b0;
        waddr       = r_head;
        raddr       = r_ptr;
        load        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_data     = '0;
                    n_position = '0;
                    n_found    = 1'b0;
                    n_status   = ST_OK;
                    unique case (i_cmd) inside
                        CMD_PUSH_FRONT: begin
                            load = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = f_dec(r_head);
                                n_head  = f_dec(r_head);
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            load = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                waddr   = f_slot(r_head, r_count[AW-1:0]);
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                load     = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                raddr   = r_head;
                                n_head  = f_inc(r_head);
                                n_count = cnt_m1;
                                n_state = S_READ;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                load     = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                raddr   = f_slot(r_head, cnt_m1[AW-1:0]);
                                n_count = cnt_m1;
                                n_state = S_READ;
                            end
                        end
                        CMD_READ: begin
                            if (bad_idx) begin
                                load     = 1'b1;
                                n_status = ST_BADIDX;
                            end else begin
                                raddr   = f_slot(r_head, idx_x[AW-1:0]);
                                n_state = S_READ;
                            end
                        end
                        CMD_WRITE: begin
                            load = 1'b1;
                            if (bad_idx) begin
                                n_status = ST_BADIDX;
                            end else begin
                                we    = 1'b1;
                                waddr = f_slot(r_head, idx_x[AW-1:0]);
                            end
                        end
                        CMD_FIND_EQ, CMD_FIND_GT: begin
                            n_gt    = (i_cmd == CMD_FIND_GT);
                            n_value = i_value;
                            if (empty) begin
                                load = 1'b1;
                            end else begin
                                raddr   = r_head;
                                n_ptr   = f_inc(r_head);
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            load    = 1'b1;
                            n_count = '0;
                            n_head  = '0;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                load    = 1'b1;
                n_data  = $signed(rdata);
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (hit) begin
                    load       = 1'b1;
                    n_found    = 1'b1;
                    n_position = 8'(r_idx);
                    n_state    = S_IDLE;
                end else if (last) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    raddr = r_ptr;
                    n_ptr = f_inc(r_ptr);
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
            n_out_count = 9'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_idx       <= n_idx;
        r_gt        <= n_gt;
        r_value     <= n_value;
        r_data      <= n_data;
        r_position  <= n_position;
        r_found     <= n_found;
        r_status    <= n_status;
        r_out_count <= n_out_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_data;
    assign o_position  = r_position;
    assign o_found     = r_found;
    assign o_status    = r_status;
    assign o_count     = r_out_count;

endmodule

>>> tb/bounded_deque_with_search_top_test.sv
// Self-checking testbench for the bounded deque with indexed access and search.
`timescale 1ns / 1ps

module bounded_deque_with_search_top_test
    import bdq_pkg::*;
();

    localparam int DEPTH = 256;
    localparam int MAX_IDLE = 17;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int REPORT_CAP = 100;
    localparam logic [3:0] CMD_UNUSED_FIRST = 4'd10;
    localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_ALL_ONES = -32'sd1;

    typedef struct packed {
        logic signed [31:0] data;
        logic [7:0]         position;
        logic               found;
        t_status            status;
        logic [8:0]         count;
    } t_deque_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [3:0]         i_cmd;
    logic [7:0]         i_index;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_data;
    logic [7:0]         o_position;
    logic               o_found;
    logic [1:0]         o_status;
    logic [8:0]         o_count;

    logic signed [31:0] shadow_words [0:DEPTH-1];
    logic [7:0]         shadow_head;
    logic [8:0]         shadow_count;

    t_deque_result awaited_results [$];
    int  mismatch_count;
    int  cycle_count;
    int  hold_cycles;
    bit  idle_on;

    bounded_deque_with_search_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_data),
        .o_position  (o_position),
        .o_found     (o_found),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_deque_result deque_outcome(logic [3:0] cmd, logic [7:0] idx,
                                                    logic signed [31:0] val);
        t_deque_result r;
        logic [7:0]    slot;
        int            n;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_head = shadow_head - 8'd1;
                    shadow_words[shadow_head] = val;
                    shadow_count++;
                end
            end
            CMD_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = shadow_head + shadow_count[7:0];
                    shadow_words[slot] = val;
                    shadow_count++;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = shadow_words[shadow_head];
                    shadow_head = shadow_head + 8'd1;
                    shadow_count--;
                end
            end
            CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                    slot = shadow_head + shadow_count[7:0];
                    r.data = shadow_words[slot];
                end
            end
            CMD_READ: begin
                if (idx >= shadow_count) begin
                    r.status = ST_BADIDX;
                end else begin
                    slot = shadow_head + idx;
                    r.data = shadow_words[slot];
                end
            end
            CMD_WRITE: begin
                if (idx >= shadow_count) begin
                    r.status = ST_BADIDX;
                end else begin
                    slot = shadow_head + idx;
                    shadow_words[slot] = val;
                end
            end
            CMD_FIND_EQ: begin
                for (n = 0; n < shadow_count; n++) begin
                    slot = shadow_head + 8'(n);
                    if (shadow_words[slot] == val) begin
                        r.found = 1'b1;
                        r.position = 8'(n);
                        break;
                    end
                end
            end
            CMD_FIND_GT: begin
                for (n = 0; n < shadow_count; n++) begin
                    slot = shadow_head + 8'(n);
                    if (shadow_words[slot] > val) begin
                        r.found = 1'b1;
                        r.position = 8'(n);
                        break;
                    end
                end
            end
            CMD_CLEAR: begin
                shadow_count = '0;
                shadow_head = '0;
            end
            default: begin
            end
        endcase
        r.count = shadow_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    task automatic check_result();
        t_deque_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch("unexpected transaction, data", o_data, '0);
        end else begin
            want = awaited_results.pop_front();
            if (o_data !== want.data)
                report_mismatch("data", o_data, want.data);
            if (o_position !== want.position)
                report_mismatch("position", o_position, want.position);
            if (o_found !== want.found)
                report_mismatch("found", o_found, want.found);
            if (o_status !== want.status)
                report_mismatch("status", o_status, want.status);
            if (o_count !== want.count)
                report_mismatch("count", o_count, want.count);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cycles = 0;
        end else if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            check_result();
            hold_cycles = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            i_out_ready <= (hold_cycles == 0);
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready <= (hold_cycles == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Call only just after a rising edge; valid stays high across back-to-back transactions.
    task automatic send_cmd(logic [3:0] cmd, logic [7:0] idx, logic signed [31:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        awaited_results.push_back(deque_outcome(cmd, idx, val));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 15))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return WORD_ALL_ONES;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] stored_or_random();
        logic [7:0] slot;
        if (shadow_count != 0 && $urandom_range(0, 3) != 0) begin
            slot = shadow_head + 8'($urandom_range(0, shadow_count - 1));
            return shadow_words[slot];
        end
        return pick_word();
    endfunction

    function automatic logic [7:0] pick_index();
        if (shadow_count != 0 && $urandom_range(0, 7) != 0)
            return 8'($urandom_range(0, shadow_count - 1));
        return 8'($urandom);
    endfunction

    task automatic test_directed();
        idle_on = 1'b1;
        send_cmd(CMD_COUNT, 8'd0, '0);
        send_cmd(CMD_POP_FRONT, 8'd0, '0);
        send_cmd(CMD_POP_BACK, 8'd0, '0);
        send_cmd(CMD_READ, 8'd0, '0);
        send_cmd(CMD_WRITE, 8'd0, WORD_ALL_ONES);
        send_cmd(CMD_FIND_EQ, 8'd0, '0);
        send_cmd(CMD_FIND_GT, 8'd0, WORD_MIN);
        send_cmd(CMD_PUSH_BACK, 8'd0, WORD_MAX);
        send_cmd(CMD_PUSH_FRONT, 8'd0, WORD_MIN);
        send_cmd(CMD_PUSH_BACK, 8'd0, WORD_ALL_ONES);
        send_cmd(CMD_PUSH_FRONT, 8'd0, '0);
        send_cmd(CMD_READ, 8'd0, '0);
        send_cmd(CMD_READ, 8'd3, '0);
        send_cmd(CMD_READ, 8'd4, '0);
        send_cmd(CMD_READ, 8'hFF, '0);
        send_cmd(CMD_WRITE, 8'd2, 32'sh5A5A_A5A5);
        send_cmd(CMD_FIND_EQ, 8'd0, WORD_ALL_ONES);
        send_cmd(CMD_FIND_EQ, 8'd0, 32'sd12345);
        send_cmd(CMD_FIND_GT, 8'd0, WORD_ALL_ONES);
        send_cmd(CMD_FIND_GT, 8'd0, WORD_MAX);
        send_cmd(CMD_FIND_GT, 8'd0, WORD_MIN);
        send_cmd(CMD_UNUSED_FIRST, 8'hFF, WORD_ALL_ONES);
        send_cmd(CMD_UNUSED_LAST, 8'd0, '0);
        send_cmd(CMD_POP_FRONT, 8'd0, '0);
        send_cmd(CMD_POP_BACK, 8'd0, '0);
        send_cmd(CMD_CLEAR, 8'd0, '0);
        send_cmd(CMD_COUNT, 8'd0, '0);
        drain_results();
    endtask

    task automatic test_full_and_wrap();
        logic signed [31:0] word;
        idle_on = 1'b1;
        while (shadow_count < DEPTH)
            send_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, 8'($urandom),
                     pick_word());
        send_cmd(CMD_PUSH_FRONT, 8'd0, WORD_MAX);
        send_cmd(CMD_PUSH_BACK, 8'hFF, WORD_MIN);
        send_cmd(CMD_READ, 8'hFF, '0);
        send_cmd(CMD_READ, 8'd0, '0);
        word = $urandom;
        send_cmd(CMD_WRITE, 8'hFF, word);
        send_cmd(CMD_FIND_EQ, 8'd0, word);
        send_cmd(CMD_FIND_GT, 8'd0, WORD_MAX);
        send_cmd(CMD_FIND_GT, 8'd0, stored_or_random());
        send_cmd(CMD_COUNT, 8'd0, '0);
        idle_on = 1'b0;
        repeat (200) send_cmd(CMD_POP_FRONT, 8'd0, '0);
        idle_on = 1'b1;
        while (shadow_count != 0)
            send_cmd($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, 8'd0, '0);
        send_cmd(CMD_POP_BACK, 8'd0, '0);
        drain_results();
    endtask

    task automatic test_random_mix();
        int         phase;
        int         item;
        int         roll;
        int         push_share;
        logic [3:0] cmd;
        for (phase = 0; phase < 7; phase++) begin
            idle_on = (phase % 3 != 2);
            push_share = $urandom_range(0, 1) ? 40 : 20;
            for (item = 0; item < 200; item++) begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    send_cmd(4'($urandom), 8'($urandom), $urandom);
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < push_share) begin
                        cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                        send_cmd(cmd, 8'($urandom), pick_word());
                    end else if (roll < push_share + 15) begin
                        send_cmd(CMD_READ, pick_index(), $urandom);
                    end else if (roll < push_share + 25) begin
                        send_cmd(CMD_WRITE, pick_index(), pick_word());
                    end else if (roll < push_share + 33) begin
                        send_cmd(CMD_FIND_EQ, 8'($urandom), stored_or_random());
                    end else if (roll < push_share + 40) begin
                        send_cmd(CMD_FIND_GT, 8'($urandom), stored_or_random());
                    end else if (roll < push_share + 42) begin
                        send_cmd(CMD_CLEAR, 8'($urandom), $urandom);
                    end else if (roll < push_share + 45) begin
                        cmd = $urandom_range(0, 1) ? CMD_COUNT
                                                   : 4'($urandom_range(CMD_UNUSED_FIRST,
                                                                       CMD_UNUSED_LAST));
                        send_cmd(cmd, 8'($urandom), $urandom);
                    end else begin
                        cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
                        send_cmd(cmd, 8'($urandom), $urandom);
                    end
                end
            end
        end
        drain_results();
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        shadow_head = '0;
        shadow_count = '0;
        for (int k = 0; k < DEPTH; k++)
            shadow_words[k] = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd <= CMD_COUNT;
        i_index <= '0;
        i_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_and_wrap();
        test_random_mix();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
src/bdq_pkg.sv
src/bdq_ram.sv
src/bounded_deque_with_search_top.sv
tb/bounded_deque_with_search_top_test.sv
